### sv/ptb_pkg.sv
// package for the plc timer bank: constants, command and state codes, shared types
// used by every module of the block, depends on nothing
package ptb_pkg;

    localparam int NUM_TIMERS  = 256;
    localparam int TIMER_IDX_W = 8;
    localparam int COUNT_W     = 16;
    localparam int PHASE_W     = 7;
    localparam int MINUTE_W    = 10;
    localparam int DIGIT_W     = 4;
    localparam int CMD_W       = 3;

    localparam int GROUP_B_START = 200;
    localparam int GROUP_C_START = 246;
    localparam int GROUP_D_START = 250;
    localparam int PHASE_MAX     = 99;
    localparam int MINUTE_MAX    = 599;
    localparam int MINUTE_HALF   = 300;
    localparam int PHASE_GROUP_A = 50;
    localparam int PHASE_GROUP_D = 90;
    localparam int DIGIT_MAX     = 9;
    localparam int DIGIT_B_STEP  = 7;
    localparam int DIGIT_10MS_ON = 2;
    localparam int DIGIT_1S_OFF  = 5;
    localparam int SCAN_STEP     = 10;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_EVALUATE = 3'd1,
        CMD_DISABLE  = 3'd2,
        CMD_PRESET   = 3'd3,
        CMD_COIL     = 3'd4,
        CMD_READ     = 3'd5
    } ptb_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TK_RD,
        ST_TK_WR,
        ST_CMD_RD,
        ST_CMD_WR,
        ST_FINISH
    } ptb_state_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] preset;
        logic               enable;
        logic               done;
        logic               clr_pend;
    } ptb_row_t;

    typedef struct packed {
        logic accept;
        logic mem_rd;
        logic mem_wr;
        logic sel_walk;
        logic walk_step;
        logic out_load;
    } ptb_ctrl_t;

    typedef struct packed {
        logic is_tick;
        logic tick_group;
        logic walk_last;
        logic out_free;
    } ptb_status_t;

endpackage

### sv/plc_timer_bank.sv
// plc_timer_bank: 256 timers in one memory row each, stepped by tick items
// timer commands: row read, row write, result load; a new item is taken only once the last result is loaded
// tick: walks the timer group that the tick selects, if any, then loads the result
// (one memory read and one write per timer), the largest group being timers 0..199
// reset: synchronous, clears counters, flags and the row valid bits at once
module plc_timer_bank
    import ptb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // timer_index [7:0], preset_value [23:8], coil_bit [24], zero [31:25]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command [2:0]
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // done_flag [0], count_value [16:1], flag_10ms [17], flag_100ms [18],
    // flag_1s [19], flag_1min [20], scan_time [36:21], zero [39:37]
    output logic [M_TDATA_W-1:0] m_tdata
);

    ptb_ctrl_t   ctrl;
    ptb_status_t status;

    ptb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    ptb_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .ctrl     (ctrl),
        .status   (status)
    );

endmodule

### sv/ptb_ctrl.sv
// controller state machine of the plc timer bank
// sequences timer group walks and single timer commands, depends on ptb_pkg
module ptb_ctrl
    import ptb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  ptb_status_t status,
    output ptb_ctrl_t   ctrl
);

    ptb_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!status.is_tick) begin
                        state_next = ST_CMD_RD;
                    end else if (status.tick_group) begin
                        state_next = ST_TK_RD;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_TK_RD: begin
                state_next = ST_TK_WR;
            end
            ST_TK_WR: begin
                state_next = status.walk_last ? ST_FINISH : ST_TK_RD;
            end
            ST_CMD_RD: begin
                state_next = ST_CMD_WR;
            end
            ST_CMD_WR: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                ctrl.accept = s_tvalid;
            end
            ST_TK_RD: begin
                ctrl.mem_rd   = 1'b1;
                ctrl.sel_walk = 1'b1;
            end
            ST_TK_WR: begin
                ctrl.mem_wr    = 1'b1;
                ctrl.sel_walk  = 1'b1;
                ctrl.walk_step = 1'b1;
            end
            ST_CMD_RD: begin
                ctrl.mem_rd = 1'b1;
            end
            ST_CMD_WR: begin
                ctrl.mem_wr = 1'b1;
            end
            ST_FINISH: begin
                ctrl.out_load = status.out_free;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

### sv/ptb_dp.sv
// datapath of the plc timer bank: timer memory with row valid bits, phase and
// minute counters, clock flags, scan time and the result register; depends on ptb_pkg
module ptb_dp
    import ptb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  ptb_ctrl_t            ctrl,
    output ptb_status_t          status
);

    ptb_row_t                 mem [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]    valid_reg;
    ptb_row_t                 rd_data_reg;
    logic                     rd_valid_reg;

    ptb_cmd_t                 cmd_reg;
    logic [TIMER_IDX_W-1:0]   idx_reg;
    logic [COUNT_W-1:0]       pv_reg;
    logic                     coil_reg;
    logic [TIMER_IDX_W-1:0]   walk_reg;
    logic [TIMER_IDX_W-1:0]   last_reg;

    logic [PHASE_W-1:0]       phase_reg;
    logic [DIGIT_W-1:0]       phase_ones_reg;
    logic [MINUTE_W-1:0]      minute_reg;
    logic [DIGIT_W-1:0]       minute_ones_reg;
    logic [3:0]               flags_reg;
    logic [COUNT_W-1:0]       scan_reg;

    logic                     res_done_reg;
    logic [COUNT_W-1:0]       res_count_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;

    ptb_cmd_t                 in_cmd;
    logic [TIMER_IDX_W-1:0]   addr;
    ptb_row_t                 row_cur, row_adv, row_cmd, wr_data;

    logic                     ph_wrap, grp_a, grp_b, grp_d, min_step;
    logic [PHASE_W-1:0]       phase_next;
    logic [DIGIT_W-1:0]       phase_ones_next;
    logic [MINUTE_W-1:0]      minute_inc;
    logic [DIGIT_W-1:0]       minute_ones_next;
    logic [3:0]               flags_next;
    logic [TIMER_IDX_W-1:0]   first_next, last_next;

    assign in_cmd = ptb_cmd_t'(s_tuser);
    assign addr   = ctrl.sel_walk ? walk_reg : idx_reg;

    // timer memory, read data registered
    always_ff @(posedge aclk) begin
        if (ctrl.mem_wr) begin
            mem[addr] <= wr_data;
        end
        if (ctrl.mem_rd) begin
            rd_data_reg  <= mem[addr];
            rd_valid_reg <= valid_reg[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.mem_wr) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    assign row_cur = rd_valid_reg ? rd_data_reg : '0;

    always_comb begin
        row_adv = row_cur;
        if (row_cur.enable && (row_cur.count < row_cur.preset) && !row_cur.done) begin
            row_adv.count = row_cur.count + COUNT_W'(1);
        end
    end

    always_comb begin
        row_cmd = row_cur;
        case (cmd_reg)
            CMD_EVALUATE: begin
                if (row_cur.count < row_cur.preset) begin
                    if (row_cur.done) begin
                        row_cmd.clr_pend = 1'b1;
                    end else if (row_cur.clr_pend) begin
                        row_cmd.count    = '0;
                        row_cmd.clr_pend = 1'b0;
                    end
                end else begin
                    row_cmd.done = 1'b1;
                end
            end
            CMD_DISABLE: begin
                row_cmd = '0;
            end
            CMD_PRESET: begin
                row_cmd.preset = pv_reg;
            end
            CMD_COIL: begin
                row_cmd.enable = coil_reg;
            end
            default: begin
                row_cmd = row_cur;
            end
        endcase
    end

    assign wr_data = ctrl.sel_walk ? row_adv : row_cmd;

    // tick counter arithmetic on the current counter values
    always_comb begin
        ph_wrap         = (phase_reg == PHASE_W'(PHASE_MAX));
        phase_next      = ph_wrap ? '0 : phase_reg + PHASE_W'(1);
        phase_ones_next = (phase_ones_reg == DIGIT_W'(DIGIT_MAX)) ? '0
                          : phase_ones_reg + DIGIT_W'(1);
        grp_b           = (phase_ones_next == DIGIT_W'(DIGIT_B_STEP));
        grp_a           = (phase_next == PHASE_W'(PHASE_GROUP_A));
        grp_d           = (phase_next == PHASE_W'(PHASE_GROUP_D));
        min_step        = grp_d;
        minute_inc      = min_step ? minute_reg + MINUTE_W'(1) : minute_reg;
        if (!min_step) begin
            minute_ones_next = minute_ones_reg;
        end else if (minute_ones_reg == DIGIT_W'(DIGIT_MAX)) begin
            minute_ones_next = '0;
        end else begin
            minute_ones_next = minute_ones_reg + DIGIT_W'(1);
        end

        flags_next = flags_reg;
        if (ph_wrap) begin
            flags_next[1] = 1'b1;
        end
        if (grp_b) begin
            flags_next[0] = 1'b0;
        end
        if (phase_ones_next == DIGIT_W'(DIGIT_10MS_ON)) begin
            flags_next[0] = 1'b1;
        end
        if (grp_a) begin
            flags_next[1] = 1'b0;
        end
        if (minute_ones_next == DIGIT_W'(DIGIT_1S_OFF)) begin
            flags_next[2] = 1'b0;
        end
        if (minute_ones_next == '0) begin
            flags_next[2] = 1'b1;
        end
        if (minute_inc == MINUTE_W'(MINUTE_HALF)) begin
            flags_next[3] = 1'b0;
        end
        if (minute_inc == '0) begin
            flags_next[3] = 1'b1;
        end

        if (ph_wrap) begin
            first_next = TIMER_IDX_W'(GROUP_C_START);
            last_next  = TIMER_IDX_W'(GROUP_D_START - 1);
        end else if (grp_b) begin
            first_next = TIMER_IDX_W'(GROUP_B_START);
            last_next  = TIMER_IDX_W'(GROUP_C_START - 1);
        end else if (grp_a) begin
            first_next = '0;
            last_next  = TIMER_IDX_W'(GROUP_B_START - 1);
        end else begin
            first_next = TIMER_IDX_W'(GROUP_D_START);
            last_next  = TIMER_IDX_W'(NUM_TIMERS - 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= '0;
            phase_ones_reg  <= '0;
            minute_reg      <= '0;
            minute_ones_reg <= '0;
            flags_reg       <= '0;
            scan_reg        <= '0;
        end else if (ctrl.accept && (in_cmd == CMD_TICK)) begin
            phase_reg       <= phase_next;
            phase_ones_reg  <= phase_ones_next;
            minute_reg      <= (minute_inc > MINUTE_W'(MINUTE_MAX)) ? '0 : minute_inc;
            minute_ones_reg <= minute_ones_next;
            flags_reg       <= flags_next;
            scan_reg        <= scan_reg + COUNT_W'(SCAN_STEP);
        end
    end

    // item capture, walk pointer and result fields
    always_ff @(posedge aclk) begin
        if (ctrl.accept) begin
            cmd_reg       <= in_cmd;
            idx_reg       <= s_tdata[TIMER_IDX_W-1:0];
            pv_reg        <= s_tdata[TIMER_IDX_W+COUNT_W-1:TIMER_IDX_W];
            coil_reg      <= s_tdata[TIMER_IDX_W+COUNT_W];
            walk_reg      <= first_next;
            last_reg      <= last_next;
            res_done_reg  <= 1'b0;
            res_count_reg <= '0;
        end else begin
            if (ctrl.walk_step) begin
                walk_reg <= walk_reg + TIMER_IDX_W'(1);
            end
            if (ctrl.mem_wr && !ctrl.sel_walk) begin
                res_done_reg  <= row_cmd.done;
                res_count_reg <= row_cmd.count;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            m_tdata_reg <= {3'b000, scan_reg, flags_reg[3], flags_reg[2], flags_reg[1],
                            flags_reg[0], res_count_reg, res_done_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign status.is_tick    = (in_cmd == CMD_TICK);
    assign status.tick_group = ph_wrap || grp_b || grp_a || grp_d;
    assign status.walk_last  = (walk_reg == last_reg);
    assign status.out_free   = !m_tvalid_reg || m_tready;

endmodule
